// ----- rtl/core/u2p_pkg.sv -----
package u2p_pkg;

    typedef enum logic
    {
        REQ_RX   = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    localparam logic [7:0] DUTY_RESET       = 8'd128;
    localparam logic [2:0] LAST_PHASE       = 3'd7;
    localparam logic [2:0] TX_PHASE         = 3'd0;
    localparam int         SAMPLE_PHASE_BIT = 1;
    localparam int         LEVEL_W          = 12;

    // per-item info carried from the control stage to the output stage
    typedef struct packed
    {
        logic               pwm_updated;
        logic               pop;
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               overflow;
        logic [LEVEL_W-1:0] fifo_level;
    } s1_info_t;

endpackage

// ----- rtl/core/u2p_in_if.sv -----
interface u2p_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] adc_value;

    modport source
    (
        output valid, req_type, rx_byte, adc_value,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, rx_byte, adc_value,
        output ready
    );
endinterface

// ----- rtl/core/u2p_out_if.sv -----
interface u2p_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pwm_duty;
    logic        pwm_updated;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        overflow;
    logic [11:0] fifo_level;

    modport source
    (
        output valid, pwm_duty, pwm_updated, tx_valid, tx_byte, overflow, fifo_level,
        input  ready
    );

    modport sink
    (
        input  valid, pwm_duty, pwm_updated, tx_valid, tx_byte, overflow, fifo_level,
        output ready
    );
endinterface

// ----- rtl/core/u2p_sample_ram.sv -----
module u2p_sample_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/u2p_ctrl.sv -----
module u2p_ctrl #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int CW    = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    u2p_in_if.sink            req,
    input  logic              s1_advance,
    output logic              s1_valid,
    output u2p_pkg::s1_info_t s1_info,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output logic [7:0]        ram_wr_data,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr
);
    import u2p_pkg::*;

    localparam logic [AW-1:0] LAST_IDX   = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    phase_reg, phase_next;
    logic          toggle_reg, toggle_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic          s1_valid_reg, s1_valid_next;
    s1_info_t      s1_info_reg, s1_info_next;

    logic accept;
    logic is_rx;
    logic push;
    logic tick;
    logic upd;
    logic pop;
    logic samp;
    logic [8:0] pair_sum;

    assign req.ready = !s1_valid_reg || s1_advance;
    assign accept    = req.valid && req.ready;
    assign is_rx     = (req.req_type == REQ_RX);
    assign push      = accept && is_rx && (count_reg != FULL_COUNT);
    assign tick      = accept && !is_rx;
    assign upd       = tick && (phase_reg == LAST_PHASE);
    assign pop       = upd && (count_reg != '0);
    assign samp      = tick && phase_reg[SAMPLE_PHASE_BIT];
    assign pair_sum  = {1'b0, first_reg} + {1'b0, second_reg};

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        first_next  = first_reg;
        second_next = second_reg;

        if (push)
        begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (pop)
        begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (samp)
        begin
            if (toggle_reg)
            begin
                second_next = req.adc_value;
            end
            else
            begin
                first_next = req.adc_value;
            end
            toggle_next = !toggle_reg;
        end
        if (tick)
        begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_info_next  = s1_info_reg;
        if (req.ready)
        begin
            s1_valid_next            = accept;
            s1_info_next.pwm_updated = upd;
            s1_info_next.pop         = pop;
            s1_info_next.tx_valid    = tick && (phase_reg == TX_PHASE);
            s1_info_next.tx_byte     = (tick && (phase_reg == TX_PHASE)) ? pair_sum[8:1] : 8'd0;
            s1_info_next.overflow    = accept && is_rx && (count_reg == FULL_COUNT);
            s1_info_next.fifo_level  = LEVEL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            phase_reg    <= '0;
            toggle_reg   <= 1'b0;
            first_reg    <= '0;
            second_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            toggle_reg   <= toggle_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_info_reg <= s1_info_next;
    end

    assign s1_valid    = s1_valid_reg;
    assign s1_info     = s1_info_reg;
    assign ram_wr_en   = push;
    assign ram_wr_addr = wr_idx_reg;
    assign ram_wr_data = req.rx_byte;
    assign ram_rd_en   = pop;
    assign ram_rd_addr = rd_idx_reg;

endmodule

// ----- rtl/core/uart_to_pwm_sample_fifo.sv -----
// a word accepted passes through the control-stage register and then the output register
// throughput: one word per cycle while the output is not stalled; each word makes at most one access to the sample ram
// a popped sample comes from the ram's registered read port, which holds it until the control stage hands its word on
// reset: asynchronous, active low; clears indices, count, phase, held samples and
// valid flags, sets duty and idle level to 128; ram contents stay undefined
module uart_to_pwm_sample_fifo #(
    parameter int FIFO_DEPTH = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    u2p_in_if.sink     req,
    u2p_out_if.source  rsp,
    input  logic       idle_level_we,
    input  logic [7:0] idle_level_wdata
);
    import u2p_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic          s1_valid;
    s1_info_t      s1_info;
    logic          s1_advance;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic       pipe_empty;
    logic [7:0] idle_level_reg;
    logic [7:0] duty_reg, duty_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_duty_reg;
    s1_info_t   out_info_reg;

    u2p_ctrl #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .s1_advance  (s1_advance),
        .s1_valid    (s1_valid),
        .s1_info     (s1_info),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    u2p_sample_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign pipe_empty = !out_valid_reg && !s1_valid;

    always_comb
    begin
        duty_next = duty_reg;
        if (s1_valid && s1_advance && s1_info.pwm_updated)
        begin
            duty_next = s1_info.pop ? ram_rd_data : idle_level_reg;
        end
    end

    assign out_valid_next = s1_advance ? s1_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_level_reg <= DUTY_RESET;
            duty_reg       <= DUTY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (idle_level_we)
            begin
                idle_level_reg <= idle_level_wdata;
            end
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid)
        begin
            out_duty_reg <= duty_next;
            out_info_reg <= s1_info;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pwm_duty    = out_duty_reg;
    assign rsp.pwm_updated = out_info_reg.pwm_updated;
    assign rsp.tx_valid    = out_info_reg.tx_valid;
    assign rsp.tx_byte     = out_info_reg.tx_byte;
    assign rsp.overflow    = out_info_reg.overflow;
    assign rsp.fifo_level  = out_info_reg.fifo_level;

    // a word is either a serial byte or a tick, never both kinds of result
    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overflow |-> !rsp.pwm_updated && !rsp.tx_valid)
        else $error("overflow reported together with tick result");

    // input stalls only when the output word is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("input stalled without output backpressure");

    // the ram never reads the entry it writes in the same cycle
    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
        else $error("sample ram read and write to same entry");

    // an empty pipeline has no pending pop depending on ram data
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_empty |-> !ram_rd_en || req.valid)
        else $error("ram read issued with no accepted word");

endmodule

// ----- sim/tb_uart_to_pwm_sample_fifo.sv -----
module tb_uart_to_pwm_sample_fifo;
    import u2p_pkg::*;

    localparam int DEPTH       = 2048;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 24;
    localparam int BURST_LEN   = 48;

    typedef struct packed
    {
        logic [7:0]         pwm_duty;
        logic               pwm_updated;
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               overflow;
        logic [LEVEL_W-1:0] fifo_level;
    } bridge_out_t;

    logic       clk;
    logic       rst_n;
    logic       idle_level_we;
    logic [7:0] idle_level_wdata;

    u2p_in_if  req_if();
    u2p_out_if rsp_if();

    uart_to_pwm_sample_fifo #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req_if),
        .rsp              (rsp_if),
        .idle_level_we    (idle_level_we),
        .idle_level_wdata (idle_level_wdata)
    );

    // bridge state as predicted
    logic [7:0]  sample_mem [DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    int          held;
    logic [2:0]  phase;
    logic        adc_toggle;
    logic [7:0]  first_adc;
    logic [7:0]  second_adc;
    logic [7:0]  duty;
    logic [7:0]  idle_level;

    bridge_out_t expected_outputs[$];
    int          errors         = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want,
                     cycle_count);
    endtask

    // outputs and ready are stable by the falling edge; the word moves at the next rise
    always @(negedge clk)
    begin : out_check
        bridge_out_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_outputs.pop_front();
                if (rsp_if.pwm_duty !== want.pwm_duty)
                    report_mismatch("pwm_duty", rsp_if.pwm_duty, want.pwm_duty);
                if (rsp_if.pwm_updated !== want.pwm_updated)
                    report_mismatch("pwm_updated", rsp_if.pwm_updated, want.pwm_updated);
                if (rsp_if.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", rsp_if.tx_valid, want.tx_valid);
                if (rsp_if.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", rsp_if.tx_byte, want.tx_byte);
                if (rsp_if.overflow !== want.overflow)
                    report_mismatch("overflow", rsp_if.overflow, want.overflow);
                if (rsp_if.fifo_level !== want.fifo_level)
                    report_mismatch("fifo_level", rsp_if.fifo_level, want.fifo_level);
            end
        end
    end

    task automatic clear_bridge_state();
        wr_ptr     = 0;
        rd_ptr     = 0;
        held       = 0;
        phase      = '0;
        adc_toggle = 1'b0;
        first_adc  = '0;
        second_adc = '0;
        duty       = DUTY_RESET;
        idle_level = DUTY_RESET;
    endtask

    task automatic predict_bridge(input req_kind_t kind, input logic [7:0] rx,
                                  input logic [7:0] adc);
        bridge_out_t r;
        logic [8:0]  sum;
        r = '0;
        if (kind == REQ_RX)
        begin
            if (held < DEPTH)
            begin
                sample_mem[wr_ptr] = rx;
                wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
                held++;
            end
            else
                r.overflow = 1'b1;
        end
        else
        begin
            if (phase == LAST_PHASE)
            begin
                if (held != 0)
                begin
                    duty = sample_mem[rd_ptr];
                    rd_ptr = (rd_ptr == DEPTH - 1) ? 0 : rd_ptr + 1;
                    held--;
                end
                else
                    duty = idle_level;
                r.pwm_updated = 1'b1;
            end
            // sampling on phase bit 1, alternating between the two holders
            if (phase[SAMPLE_PHASE_BIT])
            begin
                if (!adc_toggle)
                    first_adc = adc;
                else
                    second_adc = adc;
                adc_toggle = ~adc_toggle;
            end
            if (phase == TX_PHASE)
            begin
                sum = {1'b0, first_adc} + {1'b0, second_adc};
                r.tx_valid = 1'b1;
                r.tx_byte  = sum[8:1];
            end
            phase = phase + 3'd1;
        end
        r.pwm_duty   = duty;
        r.fifo_level = held[LEVEL_W-1:0];
        expected_outputs.push_back(r);
    endtask

    // called in the time step of a rising edge; returns in the step of the accepting edge
    task automatic send_word(input req_kind_t kind, input logic [7:0] rx,
                             input logic [7:0] adc);
        int   gap;
        logic accepted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.rx_byte   <= rx;
        req_if.adc_value <= adc;
        do
        begin
            @(negedge clk);
            accepted = req_if.ready;
            @(posedge clk);
        end
        while (!accepted);
        predict_bridge(kind, rx, adc);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_idle_level(input logic [7:0] value);
        wait_drained();
        idle_level_we    <= 1'b1;
        idle_level_wdata <= value;
        @(posedge clk);
        idle_level_we <= 1'b0;
        idle_level = value;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_reset_state();
        // first tick sits at the transmit phase with both holders cleared
        send_word(REQ_TICK, 8'hFF, 8'h00);
    endtask

    task automatic test_phase_walk();
        int i;
        // full phase cycle on an empty fifo, so the duty update falls back to idle
        for (i = 0; i < 9; i++)
            send_word(REQ_TICK, (i % 2) ? 8'hFF : 8'h00, 8'hFF);
    endtask

    task automatic test_fifo_burst();
        int i;
        for (i = 0; i < BURST_LEN; i++)
            send_word(REQ_RX, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : rand_byte(),
                      (i % 2) ? 8'hFF : 8'h00);
        // hold off until the fifo state has been seen at the output
        wait_drained();
        for (i = 0; i < 24; i++)
            send_word(REQ_TICK, rand_byte(), (i % 2) ? 8'h00 : 8'hFF);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [7:0] idle, input int count);
        int        i;
        int        push_pct;
        req_kind_t kind;
        write_idle_level(idle);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        push_pct = 15;
        for (i = 0; i < count; i++)
        begin
            // vary the push rate in stretches so the fifo both grows and runs dry
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 5;
                    1:       push_pct = 15;
                    default: push_pct = 45;
                endcase
            end
            kind = ($urandom_range(0, 99) < push_pct) ? REQ_RX : REQ_TICK;
            send_word(kind, rand_byte(), rand_byte());
        end
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_RX;
        req_if.rx_byte   = '0;
        req_if.adc_value = '0;
        rsp_if.ready     = 1'b0;
        idle_level_we    = 1'b0;
        idle_level_wdata = '0;
        clear_bridge_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_phase_walk();
        test_fifo_burst();
        test_random_traffic(0, 0, 8'hFF, 200);
        test_random_traffic(56, 0, rand_byte(), 200);
        test_random_traffic(0, 56, 8'h00, 200);
        test_random_traffic(30, 30, DUTY_RESET, 200);

        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
